[hw/rtl/rc4_keystream_cipher_core_assert.svh]
// Assertion macros for the RC4 keystream cipher core.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef RC4_KEYSTREAM_CIPHER_CORE_ASSERT_SVH
`define RC4_KEYSTREAM_CIPHER_CORE_ASSERT_SVH

`define RC4KS_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rc4ks: invariant violated");

`define RC4KS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4ks: sequence violated");

`endif

[hw/rtl/rc4ks_pkg.sv]
package rc4ks_pkg;

	localparam int BYTE_W      = 8;
	localparam int SBOX_DEPTH  = 256;
	localparam int OFIFO_DEPTH = 4;
	localparam int PTR_W       = $clog2(OFIFO_DEPTH);
	localparam int CNT_W       = $clog2(OFIFO_DEPTH + 1);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [1:0]        opcode_t;

	localparam opcode_t OP_LOAD   = 2'd0;
	localparam opcode_t OP_SETIDX = 2'd1;
	localparam opcode_t OP_CIPHER = 2'd2;

	typedef struct packed {
		byte_t data_out;
		byte_t keystream;
		logic  last_out;
	} result_t;

endpackage

[hw/rtl/rc4ks_chan_if.sv]
interface rc4ks_req_if
	import rc4ks_pkg::*;
();
	logic    valid;
	logic    ready;
	opcode_t opcode;
	byte_t   entry_index;
	byte_t   entry_value;
	byte_t   data_in;
	logic    last_in;

	modport source (output valid, output opcode, output entry_index, output entry_value,
		output data_in, output last_in, input ready);
	modport sink (input valid, input opcode, input entry_index, input entry_value,
		input data_in, input last_in, output ready);
endinterface

interface rc4ks_rsp_if
	import rc4ks_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t data_out;
	byte_t keystream;
	logic  last_out;

	modport source (output valid, output data_out, output keystream, output last_out,
		input ready);
	modport sink (input valid, input data_out, input keystream, input last_out,
		output ready);
endinterface

[hw/rtl/rc4ks_ram.sv]
module rc4ks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	// Reads return the contents from before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

[hw/rtl/rc4ks_pipe.sv]
`include "rc4_keystream_cipher_core_assert.svh"

module rc4ks_pipe
	import rc4ks_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rc4ks_req_if.sink  req,
	output logic       ram_we,
	output byte_t      ram_waddr,
	output byte_t      ram_wdata,
	output byte_t      ram_raddr_a,
	output byte_t      ram_raddr_b,
	input  byte_t      ram_rdata_a,
	input  byte_t      ram_rdata_b,
	output logic       res_valid,
	output result_t    res,
	input  logic       res_pop
);

	logic             acc;
	logic             is_cipher;
	byte_t            i_q;
	byte_t            j_q;
	byte_t            i_inc;
	byte_t            j_upd;
	byte_t            ks_addr;
	byte_t            ks;
	logic [CNT_W-1:0] credit_q;

	logic  valid_s1;
	logic  cipher_s1;
	byte_t idx_s1;
	byte_t val_s1;
	byte_t data_s1;
	logic  last_s1;

	logic  valid_s2;
	byte_t i_s2;
	byte_t a_s2;
	byte_t data_s2;
	logic  last_s2;

	logic  valid_s3;
	logic  fwd_s3;
	byte_t b_s3;
	byte_t data_s3;
	logic  last_s3;

	assign acc       = req.valid && req.ready;
	assign is_cipher = (req.opcode == OP_CIPHER);
	assign req.ready = !valid_s1 && (credit_q < CNT_W'(OFIFO_DEPTH));

	assign i_inc       = i_q + 8'd1;
	assign j_upd       = j_q + ram_rdata_a;
	assign ks_addr     = a_s2 + ram_rdata_b;
	assign ram_raddr_a = i_inc;

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = i_s2;
		ram_wdata   = ram_rdata_b;
		ram_raddr_b = ks_addr;
		if (valid_s1) begin
			ram_we = 1'b1;
			if (cipher_s1) begin
				ram_waddr   = j_upd;
				ram_wdata   = ram_rdata_a;
				ram_raddr_b = j_upd;
			end else begin
				ram_waddr = idx_s1;
				ram_wdata = val_s1;
			end
		end else if (valid_s2) begin
			ram_we = 1'b1;
		end
	end

	// A keystream read that hits the entry written in the same cycle takes the written byte.
	assign ks            = fwd_s3 ? b_s3 : ram_rdata_b;
	assign res_valid     = valid_s3;
	assign res.keystream = ks;
	assign res.data_out  = data_s3 ^ ks;
	assign res.last_out  = last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			valid_s1  <= 1'b0;
			cipher_s1 <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			credit_q  <= '0;
		end else begin
			valid_s1  <= acc && (is_cipher || req.opcode == OP_LOAD);
			cipher_s1 <= acc && is_cipher;
			valid_s2  <= valid_s1 && cipher_s1;
			valid_s3  <= valid_s2;
			if (acc) begin
				case (req.opcode)
					OP_CIPHER: begin
						i_q <= i_inc;
					end
					OP_SETIDX: begin
						i_q <= req.entry_index;
						j_q <= req.entry_value;
					end
					default: begin
					end
				endcase
			end
			if (valid_s1 && cipher_s1) begin
				j_q <= j_upd;
			end
			if (acc && is_cipher && !res_pop) begin
				credit_q <= credit_q + CNT_W'(1);
			end else if (!(acc && is_cipher) && res_pop) begin
				credit_q <= credit_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1  <= is_cipher ? i_inc : req.entry_index;
			val_s1  <= req.entry_value;
			data_s1 <= req.data_in;
			last_s1 <= req.last_in;
		end
		if (valid_s1) begin
			i_s2    <= idx_s1;
			a_s2    <= ram_rdata_a;
			data_s2 <= data_s1;
			last_s2 <= last_s1;
		end
		if (valid_s2) begin
			fwd_s3  <= (ks_addr == i_s2);
			b_s3    <= ram_rdata_b;
			data_s3 <= data_s2;
			last_s3 <= last_s2;
		end
	end

	`RC4KS_ASSERT(a_single_write, !(valid_s1 && valid_s2))
	`RC4KS_ASSERT(a_credit_bound, credit_q <= CNT_W'(OFIFO_DEPTH))
	`RC4KS_ASSERT_NEXT(a_cipher_enters, acc && is_cipher, valid_s1 && cipher_s1)
	`RC4KS_ASSERT_NEXT(a_result_follows, valid_s2, valid_s3)

endmodule

[hw/rtl/rc4ks_ofifo.sv]
`include "rc4_keystream_cipher_core_assert.svh"

module rc4ks_ofifo
	import rc4ks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  result_t     din,
	rc4ks_rsp_if.source rsp,
	output logic        pop
);

	result_t          entries_q [OFIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	result_t          head;

	assign head          = entries_q[rptr_q];
	assign rsp.valid     = (count_q != '0);
	assign rsp.data_out  = head.data_out;
	assign rsp.keystream = head.keystream;
	assign rsp.last_out  = head.last_out;
	assign pop           = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= din;
		end
	end

	`RC4KS_ASSERT(a_no_overflow, !push || count_q != CNT_W'(OFIFO_DEPTH))

endmodule

[hw/rtl/rc4_keystream_cipher_core.sv]
// RC4 keystream generator with XOR cipher on a 256-entry byte table in a RAM.
// A data byte's result passes through stages s1, s2 and s3 and the result queue before it appears on rsp.
// A new request is not taken while a data byte or table load is in the stage that writes
// the table or while the result queue has no credit left; index sets and unused opcodes skip that stage.
// Reset clears both indices and the result queue; the table is not cleared and must be
// loaded in full before data bytes are sent.
module rc4_keystream_cipher_core
	import rc4ks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rc4ks_req_if.sink   req,
	rc4ks_rsp_if.source rsp
);

	logic    ram_we;
	byte_t   ram_waddr;
	byte_t   ram_wdata;
	byte_t   ram_raddr_a;
	byte_t   ram_raddr_b;
	byte_t   ram_rdata_a;
	byte_t   ram_rdata_b;
	logic    res_valid;
	result_t res;
	logic    res_pop;

	rc4ks_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SBOX_DEPTH)
	) u_sbox (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	rc4ks_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b),
		.res_valid   (res_valid),
		.res         (res),
		.res_pop     (res_pop)
	);

	rc4ks_ofifo u_ofifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.rsp    (rsp),
		.pop    (res_pop)
	);

endmodule
